@@ hw/rtl/dbd_pkg.sv @@
// Shared widths, codes and sequencer states of the deauthentication burst detector.
package dbd_pkg;

  localparam int ADDR_W   = 48;
  localparam int CHAN_W   = 8;
  localparam int TIME_W   = 40;
  localparam int WIN_W    = 32;
  localparam int SUBT_W   = 4;
  localparam int FRAMES_W = 5;

  localparam logic [SUBT_W-1:0] SUBTYPE_DISASSOC = 4'd10;
  localparam logic [SUBT_W-1:0] SUBTYPE_DEAUTH   = 4'd12;
  localparam logic [WIN_W-1:0]  WINDOW_RESET     = 32'd10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic scan;
    logic write;
    logic check;
    logic load_out;
  } ctrl_t;

endpackage

@@ hw/rtl/dbd_frame_if.sv @@
// Channel interfaces for received frames and detector results.
interface dbd_frame_if;
  import dbd_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_wifi;
  logic [SUBT_W-1:0] frame_subtype;
  logic [ADDR_W-1:0] source_address;
  logic [CHAN_W-1:0] radio_channel;
  logic [TIME_W-1:0] time_ms;
  modport source (output valid, is_wifi, frame_subtype, source_address, radio_channel,
                  time_ms, input ready);
  modport sink (input valid, is_wifi, frame_subtype, source_address, radio_channel,
                time_ms, output ready);
endinterface

interface dbd_result_if;
  import dbd_pkg::*;
  logic                valid;
  logic                ready;
  logic                burst_detected;
  logic [FRAMES_W-1:0] frames_recorded;
  modport source (output valid, burst_detected, frames_recorded, input ready);
  modport sink (input valid, burst_detected, frames_recorded, output ready);
endinterface

@@ hw/rtl/deauth_burst_detector_core.sv @@
// Top level of the deauthentication burst detector: tag scan, timestamp ring and result register.
// Each accepted frame beat gives exactly one result beat. An ignored frame (not wifi, or a
// subtype other than disassociation or deauthentication) goes from idle straight to finish. A
// counted frame walks the tag memory one entry per cycle until a hit or the last entry; then
// the write state writes the tag and timestamp memories and reads the oldest ring time back,
// and the wait state checks it. The next frame is accepted once the current result sits in
// the output register, even if that result has not yet been taken. No clearing pass is needed
// after reset: entry valid bits are flip-flops, and a ring slot is only compared once it holds a
// time written since the entry was allocated.
module deauth_burst_detector_core #(
  parameter int TABLE_ENTRIES = 8,
  parameter int BURST_FRAMES  = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  dbd_frame_if.sink                   frame_in,
  dbd_result_if.source                result_out,
  input  logic                        cfg_write_en,
  input  logic [dbd_pkg::WIN_W-1:0]   cfg_write_data
);
  import dbd_pkg::*;

  localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW  = $clog2(BURST_FRAMES + 1);
  localparam int SW  = $clog2(BURST_FRAMES);
  localparam int TSD = TABLE_ENTRIES * BURST_FRAMES;
  localparam int TSW = $clog2(TSD);

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] last_time;
    logic [CW-1:0]     frame_count;
    logic [SW-1:0]     write_slot;
  } tag_t;

  tag_t              tag_mem [TABLE_ENTRIES];
  logic [TIME_W-1:0] ts_mem  [TSD];

  state_t state, state_next;
  ctrl_t  ctrl;

  logic [WIN_W-1:0]     window;
  logic [TABLE_ENTRIES-1:0] entry_valid;

  logic [ADDR_W-1:0] addr_r;
  logic [CHAN_W-1:0] chan_r;
  logic [TIME_W-1:0] time_r;

  tag_t              tag_q;
  logic [IW-1:0]     tag_raddr;
  logic [IW-1:0]     scan_idx;
  logic              have_free;
  logic [IW-1:0]     free_idx;
  logic [IW-1:0]     best_idx;
  logic [TIME_W-1:0] best_time;

  logic [IW-1:0]     sel_idx;
  logic [CW-1:0]     sel_count;
  logic [SW-1:0]     sel_slot;
  logic [CW-1:0]     cnt_r;

  logic [TIME_W-1:0] ts_q;
  logic [TSW-1:0]    ts_waddr;
  logic [TSW-1:0]    ts_raddr;

  logic                res_burst;
  logic [FRAMES_W-1:0] res_count;
  logic                out_valid;
  logic                out_burst;
  logic [FRAMES_W-1:0] out_count;

  logic              counted;
  logic              scan_last;
  logic              entry_hit;
  logic              free_now;
  logic [IW-1:0]     free_idx_now;
  logic              best_take;
  logic [IW-1:0]     victim_idx;
  logic [SW-1:0]     slot_next;
  logic [CW-1:0]     cnt_new;
  logic              out_free;

  assign counted = frame_in.is_wifi && (frame_in.frame_subtype == SUBTYPE_DISASSOC ||
                                        frame_in.frame_subtype == SUBTYPE_DEAUTH);
  assign scan_last    = (scan_idx == IW'(TABLE_ENTRIES - 1));
  assign entry_hit    = entry_valid[scan_idx] && (tag_q.address == addr_r) &&
                        (tag_q.channel == chan_r);
  assign free_now     = have_free || !entry_valid[scan_idx];
  assign free_idx_now = have_free ? free_idx : scan_idx;
  assign best_take    = (scan_idx == '0) || (tag_q.last_time < best_time);
  assign victim_idx   = free_now ? free_idx_now : (best_take ? scan_idx : best_idx);
  assign slot_next    = (sel_slot == SW'(BURST_FRAMES - 1)) ? '0 : sel_slot + 1'b1;
  assign cnt_new      = (sel_count < CW'(BURST_FRAMES)) ? sel_count + 1'b1 : sel_count;
  assign ts_waddr     = TSW'(sel_idx) * TSW'(BURST_FRAMES) + TSW'(sel_slot);
  assign ts_raddr     = TSW'(sel_idx) * TSW'(BURST_FRAMES) + TSW'(slot_next);
  assign out_free     = !out_valid || result_out.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (frame_in.valid) begin
          state_next = counted ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (entry_hit || scan_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE:  state_next = ST_WAIT;
      ST_WAIT:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE:   ctrl.in_ready = 1'b1;
      ST_SCAN:   ctrl.scan     = 1'b1;
      ST_WRITE:  ctrl.write    = 1'b1;
      ST_WAIT:   ctrl.check    = 1'b1;
      ST_FINISH: ctrl.load_out = out_free;
      default:   ctrl = '0;
    endcase
  end

  assign frame_in.ready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_write_en) begin
      window <= cfg_write_data;
    end
  end

  always_comb begin
    tag_raddr = '0;
    if (ctrl.scan && !scan_last) begin
      tag_raddr = scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    tag_q <= tag_mem[tag_raddr];
    if (ctrl.write) begin
      tag_mem[sel_idx] <= '{address: addr_r, channel: chan_r, last_time: time_r,
                            frame_count: cnt_new, write_slot: slot_next};
    end
  end

  always_ff @(posedge clk) begin
    ts_q <= ts_mem[ts_raddr];
    if (ctrl.write) begin
      ts_mem[ts_waddr] <= time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ctrl.write) begin
      entry_valid[sel_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.in_ready && frame_in.valid) begin
      addr_r    <= frame_in.source_address;
      chan_r    <= frame_in.radio_channel;
      time_r    <= frame_in.time_ms;
      scan_idx  <= '0;
      have_free <= 1'b0;
      res_burst <= 1'b0;
      res_count <= '0;
    end
    if (ctrl.scan) begin
      scan_idx  <= scan_idx + 1'b1;
      have_free <= free_now;
      free_idx  <= free_idx_now;
      if (best_take) begin
        best_idx  <= scan_idx;
        best_time <= tag_q.last_time;
      end
      if (entry_hit) begin
        sel_idx   <= scan_idx;
        sel_count <= tag_q.frame_count;
        sel_slot  <= tag_q.write_slot;
      end else begin
        sel_idx   <= victim_idx;
        sel_count <= '0;
        sel_slot  <= '0;
      end
    end
    if (ctrl.write) begin
      cnt_r <= cnt_new;
    end
    if (ctrl.check) begin
      res_burst <= (cnt_r == CW'(BURST_FRAMES)) && (time_r >= ts_q) &&
                   ((time_r - ts_q) <= TIME_W'(window));
      res_count <= FRAMES_W'(cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      out_burst <= res_burst;
      out_count <= res_count;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.burst_detected  = out_burst;
  assign result_out.frames_recorded = out_count;

endmodule

@@ hw/rtl/dbd_checker.sv @@
// Port-level assertions for the deauthentication burst detector and their bind.
module dbd_checker #(
  parameter int BURST_FRAMES = 20
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_burst,
  input logic [dbd_pkg::FRAMES_W-1:0]  out_count
);
  import dbd_pkg::*;

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result beat shown right after reset.");

  a_one_frame_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Frame beat accepted while the previous frame is still in work.");

  a_burst_needs_full_ring: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_burst) |-> (out_count == FRAMES_W'(BURST_FRAMES)))
    else $error("Burst flagged without a full ring.");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_burst) && $stable(out_count)))
    else $error("Stalled result beat changed.");

endmodule

bind deauth_burst_detector_core dbd_checker #(
  .BURST_FRAMES(BURST_FRAMES)
) u_dbd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (frame_in.valid),
  .in_ready  (frame_in.ready),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_burst (result_out.burst_detected),
  .out_count (result_out.frames_recorded)
);
